// ===== src/cfr_pkg.sv =====
package cfr_pkg;

  localparam logic [7:0] MARKER_RESET = 8'd170;

  // Parser phase; codes 6 and 7 are unused and fall back to idle.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_ID      = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] frame_type;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
  } result_t;

endpackage

// ===== src/cfr_parser.sv =====
module cfr_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output cfr_pkg::result_t  res
);

  cfr_pkg::phase_t phase, phase_next;
  logic [7:0] start_marker;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_type, held_type_next;
  logic [7:0] held_id, held_id_next;
  logic [7:0] held_length, held_length_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] sum_plus;
  logic [7:0] count_plus;

  assign sum_plus   = running_sum + rx_byte;
  assign count_plus = payload_count + 8'd1;

  // next state
  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    held_type_next     = held_type;
    held_id_next       = held_id;
    held_length_next   = held_length;
    payload_count_next = payload_count;
    case (phase)
      cfr_pkg::PH_IDLE: begin
        if (rx_byte == start_marker) begin
          running_sum_next = rx_byte;
          phase_next       = cfr_pkg::PH_TYPE;
        end
      end
      cfr_pkg::PH_TYPE: begin
        running_sum_next = sum_plus;
        held_type_next   = rx_byte;
        phase_next       = cfr_pkg::PH_ID;
      end
      cfr_pkg::PH_ID: begin
        running_sum_next = sum_plus;
        held_id_next     = rx_byte;
        phase_next       = cfr_pkg::PH_LENGTH;
      end
      cfr_pkg::PH_LENGTH: begin
        running_sum_next   = sum_plus;
        held_length_next   = rx_byte;
        payload_count_next = 8'd0;
        phase_next = (rx_byte == 8'd0) ? cfr_pkg::PH_CHECK : cfr_pkg::PH_PAYLOAD;
      end
      cfr_pkg::PH_PAYLOAD: begin
        running_sum_next   = sum_plus;
        payload_count_next = count_plus;
        if (count_plus >= held_length) begin
          phase_next = cfr_pkg::PH_CHECK;
        end
      end
      cfr_pkg::PH_CHECK: begin
        phase_next = cfr_pkg::PH_IDLE;
      end
      default: begin
        phase_next = cfr_pkg::PH_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    res_valid        = 1'b0;
    res.kind         = cfr_pkg::KIND_DATA;
    res.frame_type   = held_type;
    res.frame_id     = held_id;
    res.frame_length = held_length;
    res.byte_index   = 8'd0;
    res.byte_value   = rx_byte;
    case (phase)
      cfr_pkg::PH_PAYLOAD: begin
        res_valid      = 1'b1;
        res.byte_index = payload_count;
      end
      cfr_pkg::PH_CHECK: begin
        res_valid = 1'b1;
        res.kind  = (running_sum == rx_byte) ? cfr_pkg::KIND_GOOD : cfr_pkg::KIND_BAD;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= cfr_pkg::MARKER_RESET;
    end else if (cfg_we) begin
      start_marker <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= cfr_pkg::PH_IDLE;
      running_sum   <= 8'd0;
      held_type     <= 8'd0;
      held_id       <= 8'd0;
      held_length   <= 8'd0;
      payload_count <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      held_type     <= held_type_next;
      held_id       <= held_id_next;
      held_length   <= held_length_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

// ===== src/cfr_skid.sv =====
module cfr_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cfr_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output cfr_pkg::result_t  out_data
);

  logic             main_valid;
  logic             skid_valid;
  cfr_pkg::result_t main_data;
  cfr_pkg::result_t skid_data;
  logic             pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // push only happens while the skid slot is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (push && main_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      if (skid_valid) begin
        main_valid <= 1'b1;
      end else if (push) begin
        main_valid <= 1'b1;
      end else if (pop) begin
        main_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

// ===== src/checksummed_frame_receiver.sv =====
// Length-prefixed frame receiver with an 8-bit additive checksum. Each
// accepted rx_byte transaction is one byte off the link; a frame is the
// start marker, type, id, length, that many payload bytes and a checksum
// equal to the mod-256 sum of all bytes before it. Every payload byte is
// delivered as one output transaction (kind = data) tagged with the frame
// header and its index; the checksum byte delivers one frame-end
// transaction (kind = good or bad) carrying the received checksum byte.
// Bytes seen while idle that are not the marker produce nothing, nor do
// header bytes. Throughput is one byte per cycle while in_stall is low: the
// parser state updates at the edge that accepts a byte, and the result of
// that byte lands in the output register or skid slot at that same edge.
// A two-entry output buffer lets input keep flowing for one result while
// out_stall is high; in_stall rises only once both entries are occupied.
// start_marker is written through cfg_we/cfg_data (reset value 0xAA) and
// should only change while no frame is in flight.
module checksummed_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] frame_type,
  output logic [7:0] frame_id,
  output logic [7:0] frame_length,
  output logic [7:0] byte_index,
  output logic [7:0] byte_value
);

  logic             step;
  logic             res_valid;
  logic             buf_full;
  cfr_pkg::result_t res;
  cfr_pkg::result_t out_data;

  // A byte is taken whenever the buffer has room; stall comes straight
  // from a register so it never depends on in_valid.
  assign in_stall = buf_full;
  assign step     = in_valid && !buf_full;

  cfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .step      (step),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register plus skid slot.
  cfr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (step && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind         = out_data.kind;
  assign frame_type   = out_data.frame_type;
  assign frame_id     = out_data.frame_id;
  assign frame_length = out_data.frame_length;
  assign byte_index   = out_data.byte_index;
  assign byte_value   = out_data.byte_value;

endmodule

// ===== tb/checksummed_frame_receiver_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the checksummed frame receiver.
// Stimulus is a byte stream: directed frames first, then random traffic that is
// mostly frames with random header and payload and a good or corrupted checksum,
// mixed with idle noise and truncated frames. A scoreboard model tracks the parser
// state and queues an expected result per accepted payload or checksum byte.
module checksummed_frame_receiver_test;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] frame_type;
  logic [7:0] frame_id;
  logic [7:0] frame_length;
  logic [7:0] byte_index;
  logic [7:0] byte_value;

  checksummed_frame_receiver uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .frame_type   (frame_type),
    .frame_id     (frame_id),
    .frame_length (frame_length),
    .byte_index   (byte_index),
    .byte_value   (byte_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bytes waiting to go out on the input channel, and results still owed
  // by the receiver, oldest first.
  logic [7:0]       rx_pending[$];
  cfr_pkg::result_t pending_results[$];
  int               mismatch_count = 0;

  // Idle percentages, changed by the sequencer between phases.
  int sender_idle_pct = 22;
  int recv_idle_pct   = 72;

  // Scoreboard copy of the parser: register and state at their reset values.
  logic [7:0]      marker_cfg = cfr_pkg::MARKER_RESET;
  cfr_pkg::phase_t ph         = cfr_pkg::PH_IDLE;
  logic [7:0]      run_sum    = 8'd0;
  logic [7:0]      hdr_type   = 8'd0;
  logic [7:0]      hdr_id     = 8'd0;
  logic [7:0]      hdr_len    = 8'd0;
  logic [7:0]      pay_count  = 8'd0;

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    mismatch_count++;
  endtask

  // Advance the frame parser by one accepted byte; payload and checksum
  // bytes each owe one output transaction, everything else owes nothing.
  task automatic parse_rx_byte(input logic [7:0] b);
    cfr_pkg::result_t r;
    r = '0;
    r.frame_type   = hdr_type;
    r.frame_id     = hdr_id;
    r.frame_length = hdr_len;
    case (ph)
      cfr_pkg::PH_IDLE: begin
        // non-marker bytes between frames are dropped
        if (b == marker_cfg) begin
          run_sum = b;
          ph = cfr_pkg::PH_TYPE;
        end
      end
      cfr_pkg::PH_TYPE: begin
        run_sum += b;
        hdr_type = b;
        ph = cfr_pkg::PH_ID;
      end
      cfr_pkg::PH_ID: begin
        run_sum += b;
        hdr_id = b;
        ph = cfr_pkg::PH_LENGTH;
      end
      cfr_pkg::PH_LENGTH: begin
        run_sum += b;
        hdr_len = b;
        pay_count = 8'd0;
        // empty payload: next byte is already the checksum
        if (b == 8'd0) ph = cfr_pkg::PH_CHECK;
        else ph = cfr_pkg::PH_PAYLOAD;
      end
      cfr_pkg::PH_PAYLOAD: begin
        r.kind = cfr_pkg::KIND_DATA;
        r.byte_index = pay_count;
        r.byte_value = b;
        run_sum += b;
        pay_count += 8'd1;
        if (pay_count >= hdr_len) ph = cfr_pkg::PH_CHECK;
        pending_results.push_back(r);
      end
      cfr_pkg::PH_CHECK: begin
        if (run_sum == b) r.kind = cfr_pkg::KIND_GOOD;
        else r.kind = cfr_pkg::KIND_BAD;
        r.byte_index = 8'd0;
        r.byte_value = b;
        ph = cfr_pkg::PH_IDLE;
        pending_results.push_back(r);
      end
      default: ph = cfr_pkg::PH_IDLE;
    endcase
  endtask

  // Driver: presents the next pending byte when the slot is free and the
  // sender is not idling; the scoreboard sees each byte as it is accepted.
  always @(posedge clk) begin : driver
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) parse_rx_byte(rx_byte);
      if (rx_pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        rx_byte  <= rx_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure. Random stalls per cycle, plus a periodic hold-off
  // of continuous stall so the output buffer fills and the block has to stall
  // its input while the driver keeps offering bytes.
  int cycle_cnt = 0;
  int hold_left = 0;

  always @(posedge clk) begin : receiver_stall
    if (rst) begin
      out_stall <= 1'b0;
      cycle_cnt <= 0;
      hold_left <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        if (cycle_cnt % 1000 == 999) hold_left <= 120;
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Monitor: every output transaction must match the oldest expectation.
  always @(posedge clk) begin : monitor
    cfr_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %0d", kind, byte_value));
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
        if (frame_type !== want.frame_type)
          report_mismatch($sformatf("frame_type got %0d want %0d",
                                    frame_type, want.frame_type));
        if (frame_id !== want.frame_id)
          report_mismatch($sformatf("frame_id got %0d want %0d", frame_id, want.frame_id));
        if (frame_length !== want.frame_length)
          report_mismatch($sformatf("frame_length got %0d want %0d",
                                    frame_length, want.frame_length));
        if (byte_index !== want.byte_index)
          report_mismatch($sformatf("byte_index got %0d want %0d",
                                    byte_index, want.byte_index));
        if (byte_value !== want.byte_value)
          report_mismatch($sformatf("byte_value got %0d want %0d",
                                    byte_value, want.byte_value));
      end
    end
  end

  // Queue one complete frame; a bad frame gets its checksum knocked off by
  // a nonzero amount so it can never match by accident.
  task automatic queue_frame(input logic [7:0] mk, input logic [7:0] ftype,
                             input logic [7:0] fid, input logic [7:0] flen,
                             input bit good);
    logic [7:0] sum;
    logic [7:0] b;
    sum = mk + ftype + fid + flen;
    rx_pending.push_back(mk);
    rx_pending.push_back(ftype);
    rx_pending.push_back(fid);
    rx_pending.push_back(flen);
    for (int i = 0; i < flen; i++) begin
      b = 8'($urandom_range(0, 255));
      sum += b;
      rx_pending.push_back(b);
    end
    if (!good) sum += 8'($urandom_range(1, 255));
    rx_pending.push_back(sum);
  endtask

  // Random traffic: mostly frames with short payloads, some longer ones,
  // plus noise between frames and frames cut off after a partial header.
  task automatic queue_random_traffic(input int budget, input bit with_longest);
    int n;
    int pick;
    int k;
    int len;
    n = 0;
    if (with_longest) begin
      // full-length payload walks byte_index up to 254
      queue_frame(marker_cfg, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'd255, 1'b1);
      n += 260;
    end
    while (n < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        k = $urandom_range(1, 3);
        repeat (k) rx_pending.push_back(8'($urandom_range(0, 255)));
        n += k;
      end else if (pick < 14) begin
        // truncated frame: marker plus part of a header
        k = $urandom_range(0, 3);
        rx_pending.push_back(marker_cfg);
        repeat (k) rx_pending.push_back(8'($urandom_range(0, 255)));
        n += k + 1;
      end else begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 40);
        else len = $urandom_range(0, 6);
        queue_frame(marker_cfg, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'(len), $urandom_range(0, 99) >= 15);
        n += len + 5;
      end
    end
  endtask

  // Let the sender run dry and every owed result arrive, then let the clock run
  // on before returning, since header bytes leave nothing in the output to wait on.
  task automatic drain();
    while (rx_pending.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_marker(input logic [7:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    marker_cfg = value;
    @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle noise at both extremes, empty payload with good
    // checksum, extreme header values with a bad checksum, one-byte payload.
    sender_idle_pct = 22;
    recv_idle_pct   = 72;
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    queue_frame(marker_cfg, 8'h00, 8'hFF, 8'd0, 1'b1);
    queue_frame(marker_cfg, 8'hFF, 8'h00, 8'd2, 1'b0);
    queue_frame(marker_cfg, 8'h5A, 8'hA5, 8'd1, 1'b1);
    drain();

    // Marker at zero; the sender also pauses midway until all results are in.
    write_marker(8'h00);
    queue_random_traffic(160, 1'b0);
    drain();
    queue_random_traffic(160, 1'b0);
    drain();

    // Marker at all ones, idle ratios swapped.
    sender_idle_pct = 72;
    recv_idle_pct   = 22;
    write_marker(8'hFF);
    queue_random_traffic(320, 1'b0);
    drain();

    // Random marker, back-to-back transactions on both sides.
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    write_marker(8'($urandom_range(1, 254)));
    queue_random_traffic(300, 1'b1);
    drain();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== checksummed_frame_receiver.f =====
src/cfr_pkg.sv
src/cfr_parser.sv
src/cfr_skid.sv
src/checksummed_frame_receiver.sv
tb/checksummed_frame_receiver_test.sv
